/* hw/rtl/frp_pkg.sv */
`timescale 1ns / 1ps

package frp_pkg;

  localparam int unsigned NODE_COUNT_DEF  = 64;
  localparam int unsigned OFFSET_BITS_DEF = 24;

  localparam int unsigned ACT_W      = 3;
  localparam int unsigned LEN_W      = 24;
  localparam int unsigned OUT_OFF_W  = 24;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned MAXF_W     = 23;
  localparam int unsigned REGION_W   = 25;
  localparam int unsigned SPAN_W     = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [MAXF_W-1:0]   MAXF_RST   = 23'd262144;
  localparam logic [REGION_W-1:0] REGION_RST = 25'd16777216;
  localparam logic [SPAN_W-1:0]   SPAN_RST   = 32'd5000;

  typedef enum logic [ACT_W-1:0] {
    ACT_PROBE   = 3'd0,
    ACT_RESERVE = 3'd1,
    ACT_COMMIT  = 3'd2,
    ACT_SPLIT   = 3'd3,
    ACT_DEQUEUE = 3'd4,
    ACT_NEXT    = 3'd5,
    ACT_SEEK    = 3'd6,
    ACT_CLEAR   = 3'd7
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_COPY = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAXF   = 2'd0,
    CFG_REGION = 2'd1,
    CFG_SPAN   = 2'd2
  } cfg_e;

  // Descriptor memory read address source.
  typedef enum logic [2:0] {
    RD_WS,
    RD_RH,
    RD_PS,
    RD_PS_NX,
    RD_T_NX,
    RD_SLOT
  } rsel_e;

  // Datapath micro-operations.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,
    OP_DECODE,
    OP_CAP_WO,
    OP_CAP_RO,
    OP_PROBE,
    OP_RES_EVAL,
    OP_P_ADV,
    OP_LOAD,
    OP_KW_START,
    OP_T_ADV,
    OP_KW_CHECK,
    OP_SET_LK,
    OP_COMMIT,
    OP_SPLIT_A,
    OP_SPLIT_B,
    OP_OUT
  } op_e;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_DEC,
    S_PR_R,
    S_PR_EVAL,
    S_RS_W,
    S_RS_R,
    S_RS_P,
    S_RS_EVAL,
    S_RS_WA,
    S_RS_WB,
    S_LOAD,
    S_KW0,
    S_KW1,
    S_KW_A,
    S_KW_B,
    S_KW_END,
    S_CM_FIN,
    S_SP_A,
    S_SP_B,
    S_FETCH,
    S_OUT
  } state_e;

  typedef struct packed {
    rsel_e rsel;
    op_e   op;
    logic  in_ready;
  } dp_cmd_t;

  typedef struct packed {
    action_e action;
    logic    hit_ws;
    logic    is_key;
    logic    split_short;
    logic    kw_go;
    logic    kw_end;
    logic    res_walk;
    logic    walk_stop;
    logic    wrap;
    logic    out_free;
    logic    init_done;
    logic    in_valid;
  } dp_stat_t;

endpackage

/* hw/rtl/frame_ring_with_keyframe_prerecord_unit.sv */
`timescale 1ns / 1ps

// Frame descriptor ring with key-frame prerecord tracking. The unit keeps
// NODE_COUNT descriptors (offset, length, timestamp, key flag) over a byte
// region and executes one action per input transfer, returning exactly one
// result transfer. Items are handled one at a time by a sequencer that steps
// through descriptor memories with one read and one write port. A key-frame
// commit or split may add a prerecord walk over the descriptors from the
// prerecord start to the last key frame, a split whose remainder wraps is
// followed by a reserve, and a reserve that overruns the prerecord start steps
// over descriptors until a key frame or the write slot; the walks read one
// descriptor at a time. After each result the sequencer returns to idle before
// the next item is accepted. After reset the unit zeroes the descriptor
// memories and accepts no item during that time; configuration writes are
// taken at any time. A finished result sits in an output register, so the
// next item is accepted while it waits.

module frame_ring_with_keyframe_prerecord_unit #(
  parameter int unsigned NODE_COUNT  = frp_pkg::NODE_COUNT_DEF,
  parameter int unsigned OFFSET_BITS = frp_pkg::OFFSET_BITS_DEF,
  localparam int unsigned IDX_W  = $clog2(NODE_COUNT),
  localparam int unsigned SLOT_W = IDX_W + 1,
  localparam int unsigned IN_RAW = frp_pkg::ACT_W + IDX_W + 2 * frp_pkg::LEN_W + 1
                                   + frp_pkg::STAMP_W,
  localparam int unsigned IN_W   = ((IN_RAW + 7) / 8) * 8,
  localparam int unsigned OUT_RAW = frp_pkg::STATUS_W + 4 * SLOT_W + 3 * frp_pkg::LEN_W + 1
                                    + IDX_W,
  localparam int unsigned OUT_W  = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration: 0 max_frame_bytes, 1 region_bytes, 2 prerecord_span.
  input  logic                           cfg_we_i,
  input  logic [frp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [frp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // From bit 0: action, node_index, frame_length, split_length, key_frame,
  // time_stamp, zero fill.
  input  logic [IN_W-1:0]                s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // From bit 0: status, slot_index, slot_offset, slot_length, copy_source,
  // full_flag, buffered_count, read_slot, prerecord_slot, newest_slot, zero fill.
  output logic [OUT_W-1:0]               m_axis_tdata
);

  frp_pkg::dp_cmd_t  cmd;
  frp_pkg::dp_stat_t stat;

  // The sequencer decides which descriptor is read and which datapath
  // operation runs in each cycle; the datapath reports the decisions back.
  frp_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .stat_i(stat),
    .cmd_o (cmd)
  );

  // The datapath owns the ring indices, the configuration registers, the
  // descriptor memories and the result register.
  frp_dp #(
    .NODE_COUNT (NODE_COUNT),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i (s_axis_tvalid),
    .in_data_i  (s_axis_tdata),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

  // Input transfers are taken only while the sequencer waits for work.
  assign s_axis_tready = cmd.in_ready;

endmodule

/* hw/rtl/frp_ram.sv */
`timescale 1ns / 1ps

module frp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/frp_dp.sv */
`timescale 1ns / 1ps

module frp_dp #(
  parameter int unsigned NODE_COUNT  = frp_pkg::NODE_COUNT_DEF,
  parameter int unsigned OFFSET_BITS = frp_pkg::OFFSET_BITS_DEF,
  localparam int unsigned IDX_W  = $clog2(NODE_COUNT),
  localparam int unsigned SLOT_W = IDX_W + 1,
  localparam int unsigned IN_RAW = frp_pkg::ACT_W + IDX_W + 2 * frp_pkg::LEN_W + 1
                                   + frp_pkg::STAMP_W,
  localparam int unsigned IN_W   = ((IN_RAW + 7) / 8) * 8,
  localparam int unsigned OUT_RAW = frp_pkg::STATUS_W + 4 * SLOT_W + 3 * frp_pkg::LEN_W + 1
                                    + IDX_W,
  localparam int unsigned OUT_W  = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [frp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [frp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  input  logic [IN_W-1:0]                     in_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [OUT_W-1:0]                    out_data_o,
  input  frp_pkg::dp_cmd_t                    cmd_i,
  output frp_pkg::dp_stat_t                   stat_o
);

  localparam int unsigned AW    = ((OFFSET_BITS > 25) ? OFFSET_BITS : 25) + 2;
  localparam int unsigned LEN_W = frp_pkg::LEN_W;
  localparam int unsigned TS_W  = frp_pkg::STAMP_W;
  localparam logic [SLOT_W-1:0] NONE = SLOT_W'(NODE_COUNT);
  localparam logic [IDX_W-1:0]  LAST = IDX_W'(NODE_COUNT - 1);

  function automatic logic [IDX_W-1:0] succ(input logic [IDX_W-1:0] i);
    succ = (i == LAST) ? '0 : i + 1'b1;
  endfunction

  // Configuration registers.
  logic [frp_pkg::MAXF_W-1:0]   maxf_q;
  logic [frp_pkg::REGION_W-1:0] region_q;
  logic [frp_pkg::SPAN_W-1:0]   span_q;

  // Ring control state.
  logic [IDX_W-1:0]  ws_q, ws_d, rh_q, rh_d, ps_q, ps_d, lk_q, lk_d, clr_q, clr_d;
  logic [IDX_W-1:0]  t_q, t_d;
  logic [SLOT_W-1:0] newest_q, newest_d;
  logic              full_q, full_d;

  // Captured item and work registers.
  frp_pkg::action_e   act_q;
  logic [IDX_W-1:0]   idx_q;
  logic [LEN_W-1:0]   flen_q, slen_q;
  logic               key_q;
  logic [TS_W-1:0]    ts_q;
  logic [OFFSET_BITS-1:0] wo_q, wo_d, ro_q, ro_d;
  frp_pkg::status_e   status_q, status_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic               ovr_q, ovr_d;
  logic [LEN_W-1:0]   ovr_len_q, ovr_len_d, copy_q, copy_d;
  logic               out_valid_q, out_valid_d;
  logic [OUT_W-1:0]   out_data_q, out_data_d;

  // Descriptor memories.
  logic [IDX_W-1:0]       waddr, raddr;
  logic                   off_we, len_we, stamp_we, key_we;
  logic [OFFSET_BITS-1:0] off_wd, rd_off;
  logic [LEN_W-1:0]       len_wd, rd_len;
  logic [TS_W-1:0]        stamp_wd, rd_stamp;
  logic                   key_wd, rd_key;

  frp_ram #(.WIDTH(OFFSET_BITS), .DEPTH(NODE_COUNT)) u_off_ram (
    .clk_i, .we_i(off_we), .waddr_i(waddr), .wdata_i(off_wd), .raddr_i(raddr),
    .rdata_o(rd_off)
  );
  frp_ram #(.WIDTH(LEN_W), .DEPTH(NODE_COUNT)) u_len_ram (
    .clk_i, .we_i(len_we), .waddr_i(waddr), .wdata_i(len_wd), .raddr_i(raddr),
    .rdata_o(rd_len)
  );
  frp_ram #(.WIDTH(TS_W), .DEPTH(NODE_COUNT)) u_stamp_ram (
    .clk_i, .we_i(stamp_we), .waddr_i(waddr), .wdata_i(stamp_wd), .raddr_i(raddr),
    .rdata_o(rd_stamp)
  );
  frp_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_key_ram (
    .clk_i, .we_i(key_we), .waddr_i(waddr), .wdata_i(key_wd), .raddr_i(raddr),
    .rdata_o(rd_key)
  );

  // Derived values.
  logic [IDX_W-1:0]  ws_nx, rh_nx, ps_nx, t_nx, idx_nx, rh_new;
  logic              idx_ok, hit_ws, deq_ok;
  logic [LEN_W-1:0]  res_len, rest_len;
  logic [AW-1:0]     res_end, cm_next, sp_rest;
  logic              res_hit_r, res_hit_p, probe_full, cm_wrap, sp_wrap;
  logic [TS_W-1:0]   age;
  logic              kw_go, out_free, slot_is;
  logic [LEN_W-1:0]  off_o, len_o;
  logic [IDX_W:0]    cnt_wide;
  logic [IDX_W-1:0]  count;
  logic [SLOT_W-1:0] rd_slot, pre_slot;
  logic [OUT_RAW-1:0] out_raw;

  assign ws_nx  = succ(ws_q);
  assign rh_nx  = succ(rh_q);
  assign ps_nx  = succ(ps_q);
  assign t_nx   = succ(t_q);
  assign idx_nx = succ(idx_q);
  assign idx_ok = SLOT_W'(idx_q) < NONE;
  assign hit_ws = idx_ok && (idx_q == ws_q);
  assign deq_ok = idx_ok && (idx_q == rh_q) && (rh_q != ws_q);
  assign rh_new = deq_ok ? rh_nx : rh_q;

  assign rest_len  = flen_q - slen_q;
  assign res_len   = (act_q == frp_pkg::ACT_SPLIT) ? rest_len : flen_q;
  assign res_end   = AW'(wo_q) + AW'(res_len);
  assign res_hit_r = (wo_q < ro_q) && (res_end >= AW'(ro_q));
  // During reserve evaluation the memory returns the prerecord start entry.
  assign res_hit_p = (wo_q < rd_off) && (res_end >= AW'(rd_off));
  // During probe evaluation the memory returns the read head entry.
  assign probe_full = (ws_nx == rh_q) || ((wo_q == rd_off) && (ws_q != rh_q)) ||
                      ((wo_q < rd_off) && (AW'(wo_q) + AW'(maxf_q) > AW'(rd_off)));
  assign cm_next = AW'(wo_q) + AW'(flen_q);
  assign cm_wrap = (cm_next + AW'(maxf_q)) >= AW'(region_q);
  assign sp_rest = AW'(wo_q) + AW'(slen_q);
  assign sp_wrap = (sp_rest + AW'(maxf_q)) >= AW'(region_q);
  assign age     = ts_q - rd_stamp;
  assign kw_go   = age > span_q;
  assign out_free = !out_valid_q || out_ready_i;

  assign slot_is  = slot_q != NONE;
  assign off_o    = slot_is ? LEN_W'(rd_off) : '0;
  assign len_o    = slot_is ? (ovr_q ? ovr_len_q : rd_len) : '0;
  assign cnt_wide = (ws_q >= rh_q) ? ({1'b0, ws_q} - {1'b0, rh_q})
                                   : ({1'b0, ws_q} + (IDX_W + 1)'(NODE_COUNT) - {1'b0, rh_q});
  assign count    = cnt_wide[IDX_W-1:0];
  assign rd_slot  = (rh_q == ws_q) ? NONE : {1'b0, rh_q};
  assign pre_slot = (ps_q == ws_q) ? NONE : {1'b0, ps_q};
  assign out_raw  = {newest_q, pre_slot, rd_slot, count, full_q, copy_q, len_o, off_o,
                     slot_q, status_q};

  always_comb begin
    case (cmd_i.rsel)
      frp_pkg::RD_RH:    raddr = rh_q;
      frp_pkg::RD_PS:    raddr = ps_q;
      frp_pkg::RD_PS_NX: raddr = ps_nx;
      frp_pkg::RD_T_NX:  raddr = t_nx;
      frp_pkg::RD_SLOT:  raddr = slot_is ? slot_q[IDX_W-1:0] : '0;
      default:           raddr = ws_q;
    endcase
  end

  always_comb begin
    ws_d = ws_q; rh_d = rh_q; ps_d = ps_q; lk_d = lk_q; clr_d = clr_q; t_d = t_q;
    newest_d = newest_q; full_d = full_q;
    wo_d = wo_q; ro_d = ro_q;
    status_d = status_q; slot_d = slot_q; ovr_d = ovr_q; ovr_len_d = ovr_len_q;
    copy_d = copy_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    waddr = ws_q;
    off_we = 1'b0; len_we = 1'b0; stamp_we = 1'b0; key_we = 1'b0;
    off_wd = '0; len_wd = '0; stamp_wd = '0; key_wd = 1'b0;

    case (cmd_i.op)
      frp_pkg::OP_INIT: begin
        waddr = clr_q;
        off_we = 1'b1; len_we = 1'b1; stamp_we = 1'b1; key_we = 1'b1;
        clr_d = clr_q + 1'b1;
      end
      frp_pkg::OP_DECODE: begin
        status_d = frp_pkg::ST_NONE;
        slot_d   = NONE;
        ovr_d    = 1'b0;
        copy_d   = '0;
        case (act_q)
          frp_pkg::ACT_SPLIT: begin
            // A split aimed elsewhere only drops the write slot's key flag.
            if (idx_ok && !hit_ws) begin
              waddr  = ws_q;
              key_we = 1'b1;
              slot_d = {1'b0, ws_q};
            end
          end
          frp_pkg::ACT_DEQUEUE: begin
            rh_d = rh_new;
            if (deq_ok) status_d = frp_pkg::ST_OK;
            slot_d = (rh_new != ws_q) ? {1'b0, rh_new} : NONE;
          end
          frp_pkg::ACT_NEXT: begin
            if (idx_ok && !hit_ws) begin
              status_d = frp_pkg::ST_OK;
              slot_d   = {1'b0, idx_nx};
            end
          end
          frp_pkg::ACT_SEEK: begin
            rh_d     = lk_q;
            status_d = frp_pkg::ST_OK;
            slot_d   = (lk_q != ws_q) ? {1'b0, lk_q} : NONE;
          end
          frp_pkg::ACT_CLEAR: begin
            ws_d = '0; rh_d = '0; ps_d = '0; lk_d = '0;
            waddr = '0;
            off_we = 1'b1; len_we = 1'b1; stamp_we = 1'b1; key_we = 1'b1;
            status_d = frp_pkg::ST_OK;
          end
          default: ;
        endcase
      end
      frp_pkg::OP_CAP_WO: wo_d = rd_off;
      frp_pkg::OP_CAP_RO: ro_d = rd_off;
      frp_pkg::OP_PROBE: begin
        if (probe_full) begin
          full_d = 1'b1;
        end else begin
          full_d   = 1'b0;
          status_d = frp_pkg::ST_OK;
          slot_d   = {1'b0, ws_q};
        end
      end
      frp_pkg::OP_RES_EVAL: begin
        full_d = res_hit_r;
        slot_d = {1'b0, ws_q};
        if (act_q == frp_pkg::ACT_RESERVE) begin
          status_d = res_hit_r ? frp_pkg::ST_NONE : frp_pkg::ST_OK;
        end
      end
      frp_pkg::OP_P_ADV: ps_d = ps_nx;
      frp_pkg::OP_LOAD: begin
        wo_d = rd_off;
        len_we = 1'b1; stamp_we = 1'b1; key_we = 1'b1;
        len_wd = flen_q; stamp_wd = ts_q; key_wd = key_q;
      end
      frp_pkg::OP_KW_START: t_d = ps_q;
      frp_pkg::OP_T_ADV:    t_d = t_nx;
      frp_pkg::OP_KW_CHECK: begin
        if (rd_key && kw_go) ps_d = t_q;
      end
      frp_pkg::OP_SET_LK: lk_d = ws_q;
      frp_pkg::OP_COMMIT: begin
        waddr  = ws_nx;
        off_we = 1'b1; len_we = 1'b1; key_we = 1'b1;
        off_wd = cm_wrap ? '0 : cm_next[OFFSET_BITS-1:0];
        newest_d = {1'b0, ws_q};
        ws_d     = ws_nx;
        status_d = frp_pkg::ST_OK;
        slot_d   = {1'b0, ws_nx};
      end
      frp_pkg::OP_SPLIT_A: begin
        len_we = 1'b1;
        len_wd = slen_q;
      end
      frp_pkg::OP_SPLIT_B: begin
        waddr  = ws_nx;
        off_we = 1'b1; len_we = 1'b1; key_we = 1'b1;
        off_wd = sp_wrap ? '0 : sp_rest[OFFSET_BITS-1:0];
        len_wd = rest_len;
        ws_d   = ws_nx;
        slot_d = {1'b0, ws_nx};
        if (sp_wrap) begin
          status_d  = frp_pkg::ST_COPY;
          copy_d    = sp_rest[LEN_W-1:0];
          ovr_d     = 1'b1;
          ovr_len_d = rest_len;
        end else begin
          status_d = frp_pkg::ST_OK;
        end
      end
      frp_pkg::OP_OUT: begin
        out_valid_d = 1'b1;
        out_data_d  = OUT_W'(out_raw);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxf_q <= frp_pkg::MAXF_RST;
      region_q <= frp_pkg::REGION_RST;
      span_q <= frp_pkg::SPAN_RST;
      ws_q <= '0; rh_q <= '0; ps_q <= '0; lk_q <= '0; clr_q <= '0;
      newest_q <= NONE;
      full_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_index_i == frp_pkg::CFG_MAXF)) begin
        maxf_q <= cfg_data_i[frp_pkg::MAXF_W-1:0];
      end
      if (cfg_we_i && (cfg_index_i == frp_pkg::CFG_REGION)) begin
        region_q <= cfg_data_i[frp_pkg::REGION_W-1:0];
      end
      if (cfg_we_i && (cfg_index_i == frp_pkg::CFG_SPAN)) begin
        span_q <= cfg_data_i;
      end
      ws_q <= ws_d; rh_q <= rh_d; ps_q <= ps_d; lk_q <= lk_d; clr_q <= clr_d;
      newest_q <= newest_d;
      full_q <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_ready && in_valid_i) begin
      act_q  <= frp_pkg::action_e'(in_data_i[frp_pkg::ACT_W-1:0]);
      idx_q  <= in_data_i[frp_pkg::ACT_W +: IDX_W];
      flen_q <= in_data_i[frp_pkg::ACT_W + IDX_W +: LEN_W];
      slen_q <= in_data_i[frp_pkg::ACT_W + IDX_W + LEN_W +: LEN_W];
      key_q  <= in_data_i[frp_pkg::ACT_W + IDX_W + 2 * LEN_W];
      ts_q   <= in_data_i[frp_pkg::ACT_W + IDX_W + 2 * LEN_W + 1 +: TS_W];
    end
    t_q <= t_d;
    wo_q <= wo_d; ro_q <= ro_d;
    status_q <= status_d; slot_q <= slot_d; ovr_q <= ovr_d; ovr_len_q <= ovr_len_d;
    copy_q <= copy_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign stat_o.action      = act_q;
  assign stat_o.hit_ws      = hit_ws;
  assign stat_o.is_key      = key_q;
  assign stat_o.split_short = slen_q < flen_q;
  assign stat_o.kw_go       = kw_go;
  assign stat_o.kw_end      = t_q == lk_q;
  assign stat_o.res_walk    = !res_hit_r && res_hit_p;
  assign stat_o.walk_stop   = rd_key || (ps_q == ws_q);
  assign stat_o.wrap        = sp_wrap;
  assign stat_o.out_free    = out_free;
  assign stat_o.init_done   = clr_q == LAST;
  assign stat_o.in_valid    = in_valid_i;

endmodule

/* hw/rtl/frp_ctrl.sv */
`timescale 1ns / 1ps

module frp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  frp_pkg::dp_stat_t stat_i,
  output frp_pkg::dp_cmd_t  cmd_o
);

  frp_pkg::state_e state_q, state_d;
  logic split_rest;

  // A split whose kept part is shorter than the frame leaves a remainder node.
  assign split_rest = (stat_i.action == frp_pkg::ACT_SPLIT) && stat_i.split_short;

  always_comb begin
    state_d = state_q;
    case (state_q)
      frp_pkg::S_INIT:    if (stat_i.init_done) state_d = frp_pkg::S_IDLE;
      frp_pkg::S_IDLE:    if (stat_i.in_valid) state_d = frp_pkg::S_DEC;
      frp_pkg::S_DEC: begin
        case (stat_i.action)
          frp_pkg::ACT_PROBE:   state_d = frp_pkg::S_PR_R;
          frp_pkg::ACT_RESERVE: state_d = frp_pkg::S_RS_R;
          frp_pkg::ACT_COMMIT,
          frp_pkg::ACT_SPLIT:   state_d = stat_i.hit_ws ? frp_pkg::S_LOAD : frp_pkg::S_FETCH;
          default:              state_d = frp_pkg::S_FETCH;
        endcase
      end
      frp_pkg::S_PR_R:    state_d = frp_pkg::S_PR_EVAL;
      frp_pkg::S_PR_EVAL: state_d = frp_pkg::S_FETCH;
      frp_pkg::S_RS_W:    state_d = frp_pkg::S_RS_R;
      frp_pkg::S_RS_R:    state_d = frp_pkg::S_RS_P;
      frp_pkg::S_RS_P:    state_d = frp_pkg::S_RS_EVAL;
      frp_pkg::S_RS_EVAL: state_d = stat_i.res_walk ? frp_pkg::S_RS_WA : frp_pkg::S_FETCH;
      frp_pkg::S_RS_WA:   state_d = frp_pkg::S_RS_WB;
      frp_pkg::S_RS_WB:   state_d = stat_i.walk_stop ? frp_pkg::S_FETCH : frp_pkg::S_RS_WA;
      frp_pkg::S_LOAD: begin
        if (stat_i.is_key) state_d = frp_pkg::S_KW0;
        else state_d = split_rest ? frp_pkg::S_SP_A : frp_pkg::S_CM_FIN;
      end
      frp_pkg::S_KW0:     state_d = frp_pkg::S_KW1;
      frp_pkg::S_KW1:     state_d = stat_i.kw_go ? frp_pkg::S_KW_A : frp_pkg::S_KW_END;
      frp_pkg::S_KW_A:    state_d = frp_pkg::S_KW_B;
      frp_pkg::S_KW_B:    state_d = stat_i.kw_end ? frp_pkg::S_KW_END : frp_pkg::S_KW_A;
      frp_pkg::S_KW_END:  state_d = split_rest ? frp_pkg::S_SP_A : frp_pkg::S_CM_FIN;
      frp_pkg::S_CM_FIN:  state_d = frp_pkg::S_FETCH;
      frp_pkg::S_SP_A:    state_d = frp_pkg::S_SP_B;
      frp_pkg::S_SP_B:    state_d = stat_i.wrap ? frp_pkg::S_RS_W : frp_pkg::S_FETCH;
      frp_pkg::S_FETCH:   state_d = frp_pkg::S_OUT;
      frp_pkg::S_OUT:     if (stat_i.out_free) state_d = frp_pkg::S_IDLE;
      default:            state_d = frp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.rsel     = frp_pkg::RD_WS;
    cmd_o.op       = frp_pkg::OP_NONE;
    cmd_o.in_ready = 1'b0;
    case (state_q)
      frp_pkg::S_INIT:    cmd_o.op = frp_pkg::OP_INIT;
      frp_pkg::S_IDLE:    cmd_o.in_ready = 1'b1;
      frp_pkg::S_DEC:     cmd_o.op = frp_pkg::OP_DECODE;
      frp_pkg::S_PR_R: begin
        cmd_o.rsel = frp_pkg::RD_RH;
        cmd_o.op   = frp_pkg::OP_CAP_WO;
      end
      frp_pkg::S_PR_EVAL: cmd_o.op = frp_pkg::OP_PROBE;
      frp_pkg::S_RS_R: begin
        cmd_o.rsel = frp_pkg::RD_RH;
        cmd_o.op   = frp_pkg::OP_CAP_WO;
      end
      frp_pkg::S_RS_P: begin
        cmd_o.rsel = frp_pkg::RD_PS;
        cmd_o.op   = frp_pkg::OP_CAP_RO;
      end
      frp_pkg::S_RS_EVAL: cmd_o.op = frp_pkg::OP_RES_EVAL;
      frp_pkg::S_RS_WA: begin
        cmd_o.rsel = frp_pkg::RD_PS_NX;
        cmd_o.op   = frp_pkg::OP_P_ADV;
      end
      frp_pkg::S_LOAD:    cmd_o.op = frp_pkg::OP_LOAD;
      frp_pkg::S_KW0:     cmd_o.rsel = frp_pkg::RD_PS;
      frp_pkg::S_KW1:     cmd_o.op = frp_pkg::OP_KW_START;
      frp_pkg::S_KW_A: begin
        cmd_o.rsel = frp_pkg::RD_T_NX;
        cmd_o.op   = frp_pkg::OP_T_ADV;
      end
      frp_pkg::S_KW_B:    cmd_o.op = frp_pkg::OP_KW_CHECK;
      frp_pkg::S_KW_END:  cmd_o.op = frp_pkg::OP_SET_LK;
      frp_pkg::S_CM_FIN:  cmd_o.op = frp_pkg::OP_COMMIT;
      frp_pkg::S_SP_A:    cmd_o.op = frp_pkg::OP_SPLIT_A;
      frp_pkg::S_SP_B:    cmd_o.op = frp_pkg::OP_SPLIT_B;
      frp_pkg::S_FETCH:   cmd_o.rsel = frp_pkg::RD_SLOT;
      frp_pkg::S_OUT: begin
        cmd_o.rsel = frp_pkg::RD_SLOT;
        if (stat_i.out_free) cmd_o.op = frp_pkg::OP_OUT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frp_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sim/frame_ring_with_keyframe_prerecord_unit_test.sv */
`timescale 1ns / 1ps

module frame_ring_with_keyframe_prerecord_unit_test;
  import frp_pkg::*;

  localparam int unsigned IN_W   = 96;
  localparam int unsigned OUT_W  = 112;
  localparam int unsigned NODES  = 64;
  localparam logic [6:0]  NO_NODE = 7'd64;
  localparam longint      CYCLE_LIMIT = 4000000;

  // One result transfer, split into its fields.
  typedef struct {
    logic [1:0]  status;
    logic [6:0]  slot_index;
    logic [23:0] slot_offset;
    logic [23:0] slot_length;
    logic [23:0] copy_source;
    logic        full_flag;
    logic [5:0]  buffered_count;
    logic [6:0]  read_slot;
    logic [6:0]  prerecord_slot;
    logic [6:0]  newest_slot;
  } ring_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // From bit 0: action, node_index, frame_length, split_length, key_frame,
  // time_stamp, zero fill.
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // From bit 0: status, slot_index, slot_offset, slot_length, copy_source,
  // full_flag, buffered_count, read_slot, prerecord_slot, newest_slot.
  logic [OUT_W-1:0] m_axis_tdata;

  frame_ring_with_keyframe_prerecord_unit DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the ring: configuration, indices and descriptors.
  logic [22:0] sh_max_frame;
  logic [24:0] sh_region;
  logic [31:0] sh_span;
  logic [5:0]  sh_write;
  logic [5:0]  sh_read;
  logic [5:0]  sh_prerec;
  logic [5:0]  sh_last_key;
  logic [6:0]  sh_newest;
  logic        sh_full;
  logic [23:0] sh_off [NODES];
  logic [23:0] sh_len [NODES];
  logic [31:0] sh_stamp [NODES];
  logic        sh_key [NODES];

  logic [IN_W-1:0] pending_items [$];
  ring_result_t    expected_results [$];
  int  error_count = 0;
  int  results_seen = 0;
  int  copies_seen = 0;
  int  full_seen = 0;
  longint cycle_count = 0;
  int  action_count [8];

  // Walk from the prerecord start toward the last key frame, keeping the
  // newest key frame that is older than the span.
  task automatic prerecord_walk();
    logic [31:0] ts;
    logic [5:0]  t;
    ts = sh_stamp[sh_write];
    if (ts - sh_stamp[sh_prerec] > sh_span) begin
      t = sh_prerec;
      do begin
        t = t + 6'd1;
        if (sh_key[t] && (ts - sh_stamp[t] > sh_span)) sh_prerec = t;
      end while (t != sh_last_key);
    end
    sh_last_key = sh_write;
  endtask

  task automatic reserve_bytes(input longint len, output bit ok);
    longint wo, ro, po;
    wo = sh_off[sh_write];
    ro = sh_off[sh_read];
    po = sh_off[sh_prerec];
    if (wo < ro && wo + len >= ro) begin
      sh_full = 1'b1;
      ok = 1'b0;
    end else begin
      sh_full = 1'b0;
      ok = 1'b1;
      // The reservation overruns the prerecord start: step it forward.
      if (wo < po && wo + len >= po) begin
        do sh_prerec = sh_prerec + 6'd1;
        while (!sh_key[sh_prerec] && sh_prerec != sh_write);
      end
    end
  endtask

  task automatic close_write_slot();
    longint nxt;
    if (sh_key[sh_write]) prerecord_walk();
    nxt = longint'(sh_off[sh_write]) + sh_len[sh_write];
    if (nxt + sh_max_frame >= sh_region) nxt = 0;
    sh_newest = {1'b0, sh_write};
    sh_write = sh_write + 6'd1;
    sh_off[sh_write] = nxt[23:0];
    sh_len[sh_write] = '0;
    sh_key[sh_write] = 1'b0;
  endtask

  task automatic load_write_slot(input logic [23:0] flen, input logic key,
                                 input logic [31:0] ts);
    sh_len[sh_write] = flen;
    sh_key[sh_write] = key;
    sh_stamp[sh_write] = ts;
  endtask

  // Apply one action to the shadow ring and return the result it should give.
  task automatic predict_ring_action(input action_e act, input logic [5:0] idx,
                                     input logic [23:0] flen, input logic [23:0] slen,
                                     input logic key, input logic [31:0] ts,
                                     output ring_result_t r);
    logic [1:0]  status;
    logic [6:0]  slot;
    logic [23:0] len_over;
    logic        use_over;
    logic [23:0] copy_src;
    longint      wo, ro, rest_at;
    bit          ok;
    status = ST_NONE;
    slot = NO_NODE;
    len_over = '0;
    use_over = 1'b0;
    copy_src = '0;
    case (act)
      ACT_PROBE: begin
        wo = sh_off[sh_write];
        ro = sh_off[sh_read];
        if (sh_write + 6'd1 == sh_read || (wo == ro && sh_write != sh_read) ||
            (wo < ro && wo + sh_max_frame > ro)) begin
          sh_full = 1'b1;
        end else begin
          sh_full = 1'b0;
          status = ST_OK;
          slot = {1'b0, sh_write};
        end
      end
      ACT_RESERVE: begin
        reserve_bytes(flen, ok);
        status = ok ? ST_OK : ST_NONE;
        slot = {1'b0, sh_write};
      end
      ACT_COMMIT: begin
        if (idx == sh_write) begin
          load_write_slot(flen, key, ts);
          close_write_slot();
          status = ST_OK;
          slot = {1'b0, sh_write};
        end
      end
      ACT_SPLIT: begin
        if (idx == sh_write) begin
          load_write_slot(flen, key, ts);
          status = ST_OK;
          if (slen < sh_len[idx]) begin
            if (sh_key[idx]) prerecord_walk();
            rest_at = longint'(sh_off[idx]) + slen;
            sh_write = sh_write + 6'd1;
            sh_len[sh_write] = sh_len[idx] - slen;
            sh_len[idx] = slen;
            // A remainder past the wrap point moves to offset 0 and needs a copy.
            if (rest_at + sh_max_frame >= sh_region) begin
              sh_off[sh_write] = '0;
              copy_src = rest_at[23:0];
              status = ST_COPY;
              use_over = 1'b1;
              len_over = sh_len[sh_write];
              reserve_bytes(sh_len[sh_write], ok);
            end else begin
              sh_off[sh_write] = rest_at[23:0];
            end
          end else begin
            close_write_slot();
          end
        end
        sh_key[sh_write] = 1'b0;
        slot = {1'b0, sh_write};
      end
      ACT_DEQUEUE: begin
        if (idx == sh_read && sh_read != sh_write) begin
          sh_read = sh_read + 6'd1;
          status = ST_OK;
        end
        if (sh_read != sh_write) slot = {1'b0, sh_read};
      end
      ACT_NEXT: begin
        if (idx != sh_write) begin
          status = ST_OK;
          slot = {1'b0, idx + 6'd1};
        end
      end
      ACT_SEEK: begin
        sh_read = sh_last_key;
        status = ST_OK;
        if (sh_read != sh_write) slot = {1'b0, sh_read};
      end
      default: begin
        sh_write = '0;
        sh_read = '0;
        sh_prerec = '0;
        sh_last_key = '0;
        sh_off[0] = '0;
        sh_len[0] = '0;
        sh_stamp[0] = '0;
        sh_key[0] = 1'b0;
        status = ST_OK;
      end
    endcase
    r.status = status;
    r.slot_index = slot;
    r.slot_offset = (slot != NO_NODE) ? sh_off[slot[5:0]] : '0;
    r.slot_length = (slot == NO_NODE) ? '0 : (use_over ? len_over : sh_len[slot[5:0]]);
    r.copy_source = copy_src;
    r.full_flag = sh_full;
    r.buffered_count = sh_write - sh_read;
    r.read_slot = (sh_read == sh_write) ? NO_NODE : {1'b0, sh_read};
    r.prerecord_slot = (sh_prerec == sh_write) ? NO_NODE : {1'b0, sh_prerec};
    r.newest_slot = sh_newest;
  endtask

  // Queue one item for the driver together with the result it should produce.
  task automatic send_action(input action_e act, input logic [5:0] idx,
                             input logic [23:0] flen, input logic [23:0] slen,
                             input logic key, input logic [31:0] ts);
    ring_result_t r;
    predict_ring_action(act, idx, flen, slen, key, ts, r);
    pending_items.push_back({6'd0, ts, key, slen, flen, idx, act});
    expected_results.push_back(r);
    action_count[act]++;
  endtask

  // Writes happen only with the unit idle; the shadow copy follows at once.
  task automatic write_register(input cfg_e which, input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (which)
      CFG_MAXF:   sh_max_frame = value[22:0];
      CFG_REGION: sh_region = value[24:0];
      default:    sh_span = value;
    endcase
  endtask

  // Wait until every result has come back, then cover the longest walk.
  task automatic wait_until_idle();
    while (pending_items.size() != 0 || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Random items, mostly well-formed commit and split sequences on the write
  // slot with rising timestamps, mixed with reads and some noise.
  task automatic random_phase(input int n, input int max_len);
    logic [31:0] ts;
    int          pick;
    logic [23:0] flen;
    logic [5:0]  idx;
    ts = $urandom;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      ts = ts + $urandom_range(0, 3000);
      flen = ($urandom_range(0, 19) == 0) ? 24'($urandom) : 24'($urandom_range(0, max_len));
      idx = 6'($urandom);
      if (pick < 30)
        send_action(ACT_COMMIT, ($urandom_range(0, 9) != 0) ? sh_write : idx, flen,
                    24'($urandom), $urandom_range(0, 2) == 0, ts);
      else if (pick < 45)
        send_action(ACT_SPLIT, ($urandom_range(0, 9) != 0) ? sh_write : idx, flen,
                    ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, flen)),
                    $urandom_range(0, 2) == 0, ts);
      else if (pick < 55)
        send_action(ACT_PROBE, idx, flen, 24'($urandom), 1'($urandom), 32'($urandom));
      else if (pick < 65)
        send_action(ACT_RESERVE, idx, flen, 24'($urandom), 1'($urandom), 32'($urandom));
      else if (pick < 82)
        send_action(ACT_DEQUEUE, ($urandom_range(0, 4) != 0) ? sh_read : idx, flen,
                    24'($urandom), 1'($urandom), 32'($urandom));
      else if (pick < 90)
        send_action(ACT_NEXT, ($urandom_range(0, 5) == 0) ? sh_write : idx, flen,
                    24'($urandom), 1'($urandom), 32'($urandom));
      else if (pick < 97)
        send_action(ACT_SEEK, idx, flen, 24'($urandom), 1'($urandom), 32'($urandom));
      else
        send_action(ACT_CLEAR, idx, flen, 24'($urandom), 1'($urandom), 32'($urandom));
    end
  endtask

  // Stimulus: reset, a directed opening, then phases under several settings.
  initial begin
    sh_max_frame = MAXF_RST;
    sh_region = REGION_RST;
    sh_span = SPAN_RST;
    sh_write = '0;
    sh_read = '0;
    sh_prerec = '0;
    sh_last_key = '0;
    sh_newest = NO_NODE;
    sh_full = 1'b0;
    for (int i = 0; i < NODES; i++) begin
      sh_off[i] = '0;
      sh_len[i] = '0;
      sh_stamp[i] = '0;
      sh_key[i] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty ring, field extremes, every action, wrapping split,
    // key-frame prerecord movement, refused indices and timestamp wrap.
    send_action(ACT_PROBE, 6'd63, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 32'hFFFFFFFF);
    send_action(ACT_DEQUEUE, 6'd0, 24'd0, 24'd0, 1'b0, 32'd0);
    send_action(ACT_SEEK, 6'd0, 24'd0, 24'd0, 1'b0, 32'd0);
    send_action(ACT_NEXT, 6'd0, 24'd0, 24'd0, 1'b0, 32'd0);
    send_action(ACT_COMMIT, 6'd63, 24'd100, 24'd0, 1'b1, 32'd10);
    send_action(ACT_COMMIT, 6'd0, 24'd1000, 24'd0, 1'b1, 32'hFFFFF000);
    send_action(ACT_COMMIT, 6'd1, 24'd2000, 24'd0, 1'b0, 32'hFFFFFF00);
    send_action(ACT_COMMIT, 6'd2, 24'd500, 24'd0, 1'b1, 32'd9000);
    send_action(ACT_COMMIT, 6'd3, 24'd700, 24'd0, 1'b1, 32'd20000);
    send_action(ACT_NEXT, 6'd63, 24'd0, 24'd0, 1'b0, 32'd0);
    send_action(ACT_NEXT, 6'd2, 24'd0, 24'd0, 1'b0, 32'd0);
    send_action(ACT_SPLIT, 6'd4, 24'd600, 24'd200, 1'b1, 32'd25000);
    send_action(ACT_SPLIT, 6'd9, 24'd0, 24'd0, 1'b0, 32'd0);
    send_action(ACT_SPLIT, 6'd5, 24'hFFFFFF, 24'hFF0000, 1'b0, 32'd26000);
    send_action(ACT_RESERVE, 6'd0, 24'hFFFFFF, 24'd0, 1'b0, 32'd0);
    send_action(ACT_PROBE, 6'd0, 24'd0, 24'd0, 1'b0, 32'd0);
    send_action(ACT_DEQUEUE, 6'd7, 24'd0, 24'd0, 1'b0, 32'd0);
    send_action(ACT_DEQUEUE, 6'd0, 24'd0, 24'd0, 1'b0, 32'd0);
    send_action(ACT_SEEK, 6'd0, 24'd0, 24'd0, 1'b0, 32'd0);
    send_action(ACT_CLEAR, 6'd63, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 32'hFFFFFFFF);
    send_action(ACT_PROBE, 6'd0, 24'd0, 24'd0, 1'b0, 32'd0);
    random_phase(420, 300000);
    wait_until_idle();

    // Smallest frame and region with no prerecord span: constant wrapping.
    write_register(CFG_MAXF, 32'd1);
    write_register(CFG_REGION, 32'd3);
    write_register(CFG_SPAN, 32'd0);
    random_phase(430, 3);
    wait_until_idle();

    // A large frame limit, the full 24-bit offset region and the largest span.
    write_register(CFG_MAXF, 32'd4194304);
    write_register(CFG_REGION, 32'd16777216);
    write_register(CFG_SPAN, 32'hFFFFFFFF);
    random_phase(430, 4194304);
    wait_until_idle();

    // A small region that fills and overruns the read head often.
    write_register(CFG_MAXF, 32'd400);
    write_register(CFG_REGION, 32'd3000);
    write_register(CFG_SPAN, 32'd4000);
    random_phase(550, 500);
    wait_until_idle();

    $display("Covered %0d results over four settings: %0d copying splits, %0d full reports.",
             results_seen, copies_seen, full_seen);
    $display("Actions probe..clear: %0d %0d %0d %0d %0d %0d %0d %0d",
             action_count[0], action_count[1], action_count[2], action_count[3],
             action_count[4], action_count[5], action_count[6], action_count[7]);
    if (error_count == 0) begin
      $display("PASS frame_ring_with_keyframe_prerecord_unit");
    end else begin
      $display("FAIL frame_ring_with_keyframe_prerecord_unit");
    end
    $finish;
  end

  // A quiet window between these cycles runs both sides without idling.
  function automatic bit take_turn();
    if (cycle_count > 20000 && cycle_count < 40000) return 1'b1;
    return $urandom_range(0, 99) >= 33;
  endfunction

  // Driver: present the next item whenever the current one has been taken.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (pending_items.size() != 0 && take_turn()) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_items.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Monitor: each result transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin
    ring_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected");
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (e.status == ST_COPY) copies_seen++;
        if (e.full_flag) full_seen++;
        check_field("status", e.status, m_axis_tdata[1:0]);
        check_field("slot_index", e.slot_index, m_axis_tdata[8:2]);
        check_field("slot_offset", e.slot_offset, m_axis_tdata[32:9]);
        check_field("slot_length", e.slot_length, m_axis_tdata[56:33]);
        check_field("copy_source", e.copy_source, m_axis_tdata[80:57]);
        check_field("full_flag", e.full_flag, m_axis_tdata[81]);
        check_field("buffered_count", e.buffered_count, m_axis_tdata[87:82]);
        check_field("read_slot", e.read_slot, m_axis_tdata[94:88]);
        check_field("prerecord_slot", e.prerecord_slot, m_axis_tdata[101:95]);
        check_field("newest_slot", e.newest_slot, m_axis_tdata[108:102]);
      end
    end
    m_axis_tready <= take_turn();
  end

  // Watchdog for a stuck handshake.
  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL frame_ring_with_keyframe_prerecord_unit");
      $finish;
    end
  end

endmodule

/* files.f */
hw/rtl/frp_pkg.sv
hw/rtl/frp_ram.sv
hw/rtl/frp_dp.sv
hw/rtl/frp_ctrl.sv
hw/rtl/frame_ring_with_keyframe_prerecord_unit.sv
sim/frame_ring_with_keyframe_prerecord_unit_test.sv
